// ===== rtl/core/csv_field_splitter_typer_core_macros.svh =====
// assertion macros shared by the csv splitter rtl
`ifndef CSV_FIELD_SPLITTER_TYPER_CORE_MACROS_SVH
`define CSV_FIELD_SPLITTER_TYPER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// condition must hold at every clock edge outside reset
`define CSVFT_ASSERT_ALWAYS(name, clk, rst_n, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);
// antecedent implies consequent in the same cycle
`define CSVFT_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define CSVFT_ASSERT_ALWAYS(name, clk, rst_n, cond, msg)
`define CSVFT_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/core/csvft_pkg.sv =====
// shared types and constants of the csv field splitter
`timescale 1ns / 1ps
package csvft_pkg;

    typedef enum logic [1:0]
    {
        ACT_NONE    = 2'd0,
        ACT_CONTENT = 2'd1,
        ACT_CLOSE   = 2'd2
    } act_t;

    typedef struct packed
    {
        logic accept;
        logic load_end;
        logic load_byte;
        logic load_held;
    } csvft_cmd_t;

    typedef struct packed
    {
        logic out_free;
        act_t act;
        logic held_any;
        logic flush_last;
    } csvft_sts_t;

    localparam logic [7:0] CHAR_QUOTE = 8'h22;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0d;
    localparam logic [7:0] CHAR_LF    = 8'h0a;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_PLUS  = 8'h2b;
    localparam logic [7:0] CHAR_DOT   = 8'h2e;
    localparam logic [7:0] CHAR_COMMA = 8'h2c;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [1:0] CLASS_INT  = 2'd0;
    localparam logic [1:0] CLASS_DEC  = 2'd1;
    localparam logic [1:0] CLASS_TEXT = 2'd2;

    localparam logic       REG_DELIM   = 1'b0;
    localparam logic [7:0] DELIM_RESET = 8'd44;

endpackage

// ===== rtl/core/csvft_ctrl.sv =====
// controller state machine of the csv field splitter
`timescale 1ns / 1ps
`include "csv_field_splitter_typer_core_macros.svh"
module csvft_ctrl
    import csvft_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_valid,
    output logic       s_ready,
    input  csvft_sts_t sts,
    output csvft_cmd_t cmd
);

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_FLUSH,
        ST_BYTE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE) && sts.out_free;
    assign accept  = s_valid && s_ready;

    always_comb
    begin
        cmd.accept    = accept;
        cmd.load_end  = accept && (sts.act == ACT_CLOSE);
        cmd.load_byte = (accept && (sts.act == ACT_CONTENT) && !sts.held_any)
                        || ((state_reg == ST_BYTE) && sts.out_free);
        cmd.load_held = (state_reg == ST_FLUSH) && sts.out_free;
        state_next    = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                // held whitespace goes out ahead of the new byte
                if (accept && (sts.act == ACT_CONTENT) && sts.held_any)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (sts.out_free && sts.flush_last)
                begin
                    state_next = ST_BYTE;
                end
            end
            ST_BYTE:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `CSVFT_ASSERT_ALWAYS(a_single_load, clk, rst_n, $onehot0({cmd.load_end, cmd.load_byte, cmd.load_held}), "two result loads in one cycle")
    `CSVFT_ASSERT_IMP(a_load_needs_slot, clk, rst_n, (cmd.load_end || cmd.load_byte || cmd.load_held), sts.out_free, "result loaded over a waiting transfer")
    `CSVFT_ASSERT_IMP(a_flush_has_data, clk, rst_n, (state_reg == ST_FLUSH), sts.held_any, "flush with empty whitespace store")

endmodule

// ===== rtl/core/csvft_dp.sv =====
// datapath of the csv field splitter: field state, whitespace store, result register
`timescale 1ns / 1ps
`include "csv_field_splitter_typer_core_macros.svh"
module csvft_dp
    import csvft_pkg::*;
#(
    parameter int HELD_SPACE_DEPTH = 32,
    parameter int MAX_FIELDS       = 256
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_kind,
    input  logic [7:0] in_byte,
    input  logic [7:0] delimiter,
    input  logic       m_ready,
    input  csvft_cmd_t cmd,
    output csvft_sts_t sts,
    output logic       out_valid,
    output logic [7:0] out_byte,
    output logic       out_end,
    output logic [1:0] out_class,
    output logic [7:0] out_field,
    output logic       out_done,
    output logic       out_ovf
);

    localparam int CW = $clog2(HELD_SPACE_DEPTH + 1);
    localparam int AW = (HELD_SPACE_DEPTH > 1) ? $clog2(HELD_SPACE_DEPTH) : 1;
    localparam int FIELD_TOP_INT = ((MAX_FIELDS - 1) > 255) ? 255 : (MAX_FIELDS - 1);
    localparam logic [7:0]    FIELD_TOP = 8'(FIELD_TOP_INT);
    localparam logic [CW-1:0] DEPTH_C   = CW'(HELD_SPACE_DEPTH);

    logic          inside_quotes_reg;
    logic          quote_waiting_reg;
    logic          content_started_reg;
    logic          only_sign_reg;
    logic          point_seen_reg;
    logic          not_numeric_reg;
    logic          overflow_seen_reg;
    logic [CW-1:0] held_count_reg;
    logic [CW-1:0] fidx_reg;
    logic [CW-1:0] fidx_next;
    logic [7:0]    current_field_reg;
    logic [7:0]    pend_byte_reg;
    logic [7:0]    rd_data_reg;
    logic [7:0]    held_mem [HELD_SPACE_DEPTH];

    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic          out_end_reg;
    logic [1:0]    out_class_reg;
    logic [7:0]    out_field_reg;
    logic          out_done_reg;
    logic          out_ovf_reg;

    act_t          act;
    logic          in_quote_eff;
    logic          byte_ws;
    logic          inside_next;
    logic          quote_waiting_next;
    logic          hold_wr;
    logic          ovf_set;

    logic [7:0]    emit_byte;
    logic          only_sign_next;
    logic          point_seen_next;
    logic          not_numeric_next;
    logic [1:0]    close_class;
    logic          load_any;

    assign in_quote_eff = quote_waiting_reg ? 1'b0 : inside_quotes_reg;
    assign byte_ws      = in_byte inside {CHAR_SPACE, CHAR_TAB, CHAR_CR, CHAR_LF};

    // decode of the offered item against the quote state
    always_comb
    begin
        act                = ACT_NONE;
        inside_next        = inside_quotes_reg;
        quote_waiting_next = quote_waiting_reg;
        hold_wr            = 1'b0;
        ovf_set            = 1'b0;
        if (in_kind)
        begin
            act                = ACT_CLOSE;
            inside_next        = 1'b0;
            quote_waiting_next = 1'b0;
        end
        else if (quote_waiting_reg && (in_byte == CHAR_QUOTE))
        begin
            // doubled quote gives one literal quote
            act                = ACT_CONTENT;
            quote_waiting_next = 1'b0;
        end
        else
        begin
            quote_waiting_next = 1'b0;
            inside_next        = in_quote_eff;
            if (in_byte == CHAR_QUOTE)
            begin
                if (in_quote_eff)
                begin
                    quote_waiting_next = 1'b1;
                end
                else
                begin
                    inside_next = 1'b1;
                end
            end
            else if ((in_byte == delimiter) && !in_quote_eff)
            begin
                act = ACT_CLOSE;
            end
            else if (byte_ws)
            begin
                if (content_started_reg)
                begin
                    if (held_count_reg < DEPTH_C)
                    begin
                        hold_wr = 1'b1;
                    end
                    else
                    begin
                        ovf_set = 1'b1;
                    end
                end
            end
            else
            begin
                act = ACT_CONTENT;
            end
        end
    end

    // class tracking of the byte going out
    always_comb
    begin
        if (cmd.load_held)
        begin
            emit_byte = rd_data_reg;
        end
        else if (cmd.accept)
        begin
            emit_byte = in_byte;
        end
        else
        begin
            emit_byte = pend_byte_reg;
        end
        only_sign_next   = 1'b0;
        point_seen_next  = point_seen_reg;
        not_numeric_next = not_numeric_reg;
        if (!content_started_reg && ((emit_byte == CHAR_MINUS) || (emit_byte == CHAR_PLUS)))
        begin
            only_sign_next = 1'b1;
        end
        else if ((emit_byte == CHAR_DOT) || (emit_byte == CHAR_COMMA))
        begin
            if (point_seen_reg)
            begin
                not_numeric_next = 1'b1;
            end
            point_seen_next = 1'b1;
        end
        else if ((emit_byte < CHAR_ZERO) || (emit_byte > CHAR_NINE))
        begin
            not_numeric_next = 1'b1;
        end
    end

    always_comb
    begin
        if (!content_started_reg || only_sign_reg || not_numeric_reg)
        begin
            close_class = CLASS_TEXT;
        end
        else if (point_seen_reg)
        begin
            close_class = CLASS_DEC;
        end
        else
        begin
            close_class = CLASS_INT;
        end
    end

    always_comb
    begin
        fidx_next = fidx_reg;
        if (cmd.load_byte)
        begin
            fidx_next = '0;
        end
        else if (cmd.load_held)
        begin
            fidx_next = fidx_reg + CW'(1);
        end
    end

    assign load_any = cmd.load_end || cmd.load_byte || cmd.load_held;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_quotes_reg   <= 1'b0;
            quote_waiting_reg   <= 1'b0;
            content_started_reg <= 1'b0;
            only_sign_reg       <= 1'b0;
            point_seen_reg      <= 1'b0;
            not_numeric_reg     <= 1'b0;
            overflow_seen_reg   <= 1'b0;
            held_count_reg      <= '0;
            fidx_reg            <= '0;
            current_field_reg   <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            fidx_reg <= fidx_next;
            if (cmd.accept)
            begin
                inside_quotes_reg <= inside_next;
                quote_waiting_reg <= quote_waiting_next;
                if (ovf_set)
                begin
                    overflow_seen_reg <= 1'b1;
                end
                if (hold_wr)
                begin
                    held_count_reg <= held_count_reg + CW'(1);
                end
            end
            if (cmd.load_byte || cmd.load_held)
            begin
                content_started_reg <= 1'b1;
                only_sign_reg       <= only_sign_next;
                point_seen_reg      <= point_seen_next;
                not_numeric_reg     <= not_numeric_next;
            end
            if (cmd.load_byte)
            begin
                held_count_reg <= '0;
            end
            if (cmd.load_end)
            begin
                content_started_reg <= 1'b0;
                only_sign_reg       <= 1'b0;
                point_seen_reg      <= 1'b0;
                not_numeric_reg     <= 1'b0;
                overflow_seen_reg   <= 1'b0;
                held_count_reg      <= '0;
                if (in_kind)
                begin
                    current_field_reg <= '0;
                end
                else if (current_field_reg < FIELD_TOP)
                begin
                    current_field_reg <= current_field_reg + 8'd1;
                end
            end
            if (load_any)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pend_byte_reg <= in_byte;
        end
        if (cmd.accept && hold_wr)
        begin
            held_mem[held_count_reg[AW-1:0]] <= in_byte;
        end
        rd_data_reg <= held_mem[fidx_next[AW-1:0]];
        if (cmd.load_end)
        begin
            out_byte_reg  <= 8'd0;
            out_end_reg   <= 1'b1;
            out_class_reg <= close_class;
            out_field_reg <= current_field_reg;
            out_done_reg  <= in_kind;
            out_ovf_reg   <= overflow_seen_reg;
        end
        else if (cmd.load_byte || cmd.load_held)
        begin
            out_byte_reg  <= emit_byte;
            out_end_reg   <= 1'b0;
            out_class_reg <= CLASS_INT;
            out_field_reg <= current_field_reg;
            out_done_reg  <= 1'b0;
            out_ovf_reg   <= 1'b0;
        end
    end

    always_comb
    begin
        sts.out_free   = !out_valid_reg || m_ready;
        sts.act        = act;
        sts.held_any   = (held_count_reg != '0);
        sts.flush_last = ((fidx_reg + CW'(1)) == held_count_reg);
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_end   = out_end_reg;
    assign out_class = out_class_reg;
    assign out_field = out_field_reg;
    assign out_done  = out_done_reg;
    assign out_ovf   = out_ovf_reg;

    `CSVFT_ASSERT_ALWAYS(a_count_bound, clk, rst_n, (held_count_reg <= DEPTH_C), "whitespace count beyond store depth")

endmodule

// ===== rtl/core/csv_field_splitter_typer_core.sv =====
// top level of the csv field splitter and typer
//
//  channel   dir   signals                              carries
//  s_axis    in    tvalid tready tdata[7:0] tuser       one line byte, or end of line
//  m_axis    out   tvalid tready tdata[23:0] tuser tlast content byte or field end
//  apb       in    psel penable pwrite paddr pwdata     delimiter_char at byte address 0
//
//  a byte that leads to one result or none, and an end of line, skip the flush
//  a non-whitespace byte behind held whitespace passes the flush and byte states:
//  the held store feeds the single result register one entry a cycle
//  reset is asynchronous, active low; the held store needs no clearing pass
//  m_axis_tready low holds the result register and with it s_axis_tready
`timescale 1ns / 1ps
module csv_field_splitter_typer_core
    import csvft_pkg::*;
#(
    parameter int HELD_SPACE_DEPTH = 32,
    parameter int MAX_FIELDS       = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] kind
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [9:8] field_class,
                                        // [17:10] field_number, [18] space_overflow
    output logic        m_axis_tuser,   // [0] is_field_end
    output logic        m_axis_tlast,   // line_done
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] delimiter_reg;
    logic       cfg_write;

    csvft_cmd_t cmd;
    csvft_sts_t sts;

    logic [7:0] out_byte;
    logic       out_end;
    logic [1:0] out_class;
    logic [7:0] out_field;
    logic       out_done;
    logic       out_ovf;

    // register file: one register, word index taken from paddr[2]
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_DELIM);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delimiter_reg <= DELIM_RESET;
        end
        else if (cfg_write)
        begin
            delimiter_reg <= pwdata[7:0];
        end
    end

    // reads beyond the register list return zero
    always_comb
    begin
        if (paddr[2] == REG_DELIM)
        begin
            prdata = {24'd0, delimiter_reg};
        end
        else
        begin
            prdata = 32'd0;
        end
    end

    // sequencing of accepts, whitespace flushes and result loads
    csvft_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // quote and field state, held whitespace store, class tracking, result register
    csvft_dp #(
        .HELD_SPACE_DEPTH (HELD_SPACE_DEPTH),
        .MAX_FIELDS       (MAX_FIELDS)
    ) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_kind   (s_axis_tuser),
        .in_byte   (s_axis_tdata),
        .delimiter (delimiter_reg),
        .m_ready   (m_axis_tready),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (m_axis_tvalid),
        .out_byte  (out_byte),
        .out_end   (out_end),
        .out_class (out_class),
        .out_field (out_field),
        .out_done  (out_done),
        .out_ovf   (out_ovf)
    );

    // result transfer packing, spare top bits held at zero
    assign m_axis_tdata = {5'd0, out_ovf, out_field, out_class, out_byte};
    assign m_axis_tuser = out_end;
    assign m_axis_tlast = out_done;

endmodule
